// ----- hdl/mdr_pkg.sv -----
`timescale 1ns / 1ps

package mdr_pkg;

  // Geometry
  localparam int NUM_PORTS      = 3;
  localparam int CFG_PORTS      = 3;
  localparam int PIN_COUNT      = 24;
  localparam int CHANNELS       = NUM_PORTS * 8;
  localparam int REPORT_LEN     = 1 + CHANNELS / 2;
  localparam int DEBOUNCE_LIMIT = 5;

  // Widths
  localparam int CNT_W     = $clog2(DEBOUNCE_LIMIT + 1);
  localparam int CH_W      = $clog2(CHANNELS);
  localparam int PAIR_W    = CH_W - 1;
  localparam int POS_W     = $clog2(REPORT_LEN);
  localparam int CFG_IDX_W = $clog2(2 * CFG_PORTS);
  localparam int PORT_W    = (CFG_IDX_W > 1) ? CFG_IDX_W - 1 : 1;

  // Register select: low index bit picks enable or pull-up mask
  localparam logic SEL_ENABLE = 1'b0;
  localparam logic SEL_PULLUP = 1'b1;

  // Report constants
  localparam logic [7:0] REPORT_HEADER = 8'h40;
  localparam logic [3:0] NIB_ENABLE    = 4'h8;
  localparam logic [3:0] NIB_PULLUP    = 4'h4;
  localparam logic [3:0] NIB_LEVEL     = 4'h1;

  // Per-channel control from the top level
  typedef struct packed {
    logic sample;
    logic clear;
  } lane_ctrl_t;

endpackage

// ----- hdl/mdr_lane.sv -----
`timescale 1ns / 1ps

module mdr_lane (
  input  logic               clk,
  input  logic               rst,
  input  mdr_pkg::lane_ctrl_t ctrl,
  input  logic               enable,
  input  logic               pin,
  output logic               level
);

  logic                     prev;
  logic [mdr_pkg::CNT_W-1:0] count;

  // Compare against the kept sample and count agreement up to the limit
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      prev  <= 1'b0;
      count <= '0;
      level <= 1'b0;
    end else if (ctrl.sample && enable) begin
      prev <= pin;
      if (pin == prev) begin
        if (count < mdr_pkg::CNT_W'(mdr_pkg::DEBOUNCE_LIMIT)) begin
          count <= count + 1'b1;
          if (count == mdr_pkg::CNT_W'(mdr_pkg::DEBOUNCE_LIMIT - 1)) begin
            level <= pin;
          end
        end
      end else begin
        count <= '0;
      end
    end
  end

endmodule

// ----- hdl/mdr_report.sv -----
`timescale 1ns / 1ps

module mdr_report (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [mdr_pkg::CHANNELS-1:0] enable_vec,
  input  logic [mdr_pkg::CHANNELS-1:0] pullup_vec,
  input  logic [mdr_pkg::CHANNELS-1:0] level_vec,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   report_byte,
  output logic [3:0]                   byte_position,
  output logic                         last_byte
);

  logic [mdr_pkg::POS_W-1:0]  pos;
  logic [mdr_pkg::POS_W-1:0]  pair_pos;
  logic [mdr_pkg::PAIR_W-1:0] pair_idx;
  logic [3:0]                 nib [mdr_pkg::CHANNELS];
  logic                       is_last;

  // Build each channel nibble from the lane results
  always_comb begin
    for (int ch = 0; ch < mdr_pkg::CHANNELS; ch++) begin
      nib[ch] = (enable_vec[ch] ? mdr_pkg::NIB_ENABLE : 4'h0)
              | (pullup_vec[ch] ? mdr_pkg::NIB_PULLUP : 4'h0)
              | (level_vec[ch]  ? mdr_pkg::NIB_LEVEL  : 4'h0);
    end
  end

  // Merge the selected pair of lanes into the current byte
  always_comb begin
    pair_pos = pos - 1'b1;
    pair_idx = pair_pos[mdr_pkg::PAIR_W-1:0];
    if (pos == '0) begin
      report_byte = mdr_pkg::REPORT_HEADER;
    end else begin
      report_byte = {nib[{pair_idx, 1'b0}], nib[{pair_idx, 1'b1}]};
    end
    is_last       = (pos == mdr_pkg::POS_W'(mdr_pkg::REPORT_LEN - 1));
    last_byte     = is_last;
    byte_position = 4'(pos);
  end

  // Advance one byte per transfer, restart on a new sampling tick
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= '0;
    end else if (start) begin
      out_valid <= 1'b1;
      pos       <= '0;
    end else if (out_valid && out_ready) begin
      if (is_last) begin
        out_valid <= 1'b0;
        pos       <= '0;
      end else begin
        pos <= pos + 1'b1;
      end
    end
  end

endmodule

// ----- hdl/multi_input_debounce_reporter.sv -----
`timescale 1ns / 1ps

// Debounces 24 input channels in parallel lanes and reports their status.
// Every tick transfer toggles a parity bit; every second tick samples all
// enabled channels at once and starts a 13-byte report (header 0x40,
// then two channel nibbles per byte, even channel high), one byte per cycle
// while out_ready is high. A non-sampling tick yields no bytes. A sampling
// tick is held off while a report is still streaming. The report reads the
// lane state live, which stays fixed until the next sampling tick or a
// register write; a register write clears the state of the eight channels
// of its port.
module multi_input_debounce_reporter (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [23:0]                        pin_levels,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [7:0]                         report_byte,
  output logic [3:0]                         byte_position,
  output logic                               last_byte,
  input  logic                               cfg_we,
  input  logic [mdr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [7:0]                         cfg_data
);

  logic                         tick_parity;
  logic [7:0]                   enable_mask [mdr_pkg::NUM_PORTS];
  logic [7:0]                   pullup_mask [mdr_pkg::NUM_PORTS];
  logic [mdr_pkg::PORT_W-1:0]   cfg_port;
  logic                         cfg_hit;
  logic                         tick_xfer;
  logic                         sample;
  logic                         out_done;
  logic [mdr_pkg::CHANNELS-1:0] enable_vec;
  logic [mdr_pkg::CHANNELS-1:0] pullup_vec;
  logic [mdr_pkg::CHANNELS-1:0] level_vec;

  // Decode a register write
  always_comb begin
    cfg_port = cfg_index[mdr_pkg::CFG_IDX_W-1:1];
    cfg_hit  = cfg_we
            && (int'(cfg_index) < 2 * mdr_pkg::CFG_PORTS)
            && (int'(cfg_port) < mdr_pkg::NUM_PORTS);
  end

  // Take a sampling tick only once the serializer is free
  always_comb begin
    out_done  = out_valid && out_ready && last_byte;
    in_ready  = !tick_parity || !out_valid || out_done;
    tick_xfer = in_valid && in_ready;
    sample    = tick_xfer && tick_parity;
  end

  // Hold the tick parity
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_parity <= 1'b0;
    end else if (tick_xfer) begin
      tick_parity <= !tick_parity;
    end
  end

  // Store the mask registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < mdr_pkg::NUM_PORTS; p++) begin
        enable_mask[p] <= 8'h00;
        pullup_mask[p] <= 8'h00;
      end
    end else if (cfg_hit) begin
      for (int p = 0; p < mdr_pkg::NUM_PORTS; p++) begin
        if (int'(cfg_port) == p) begin
          if (cfg_index[0] == mdr_pkg::SEL_ENABLE) begin
            enable_mask[p] <= cfg_data;
          end
          if (cfg_index[0] == mdr_pkg::SEL_PULLUP) begin
            pullup_mask[p] <= cfg_data;
          end
        end
      end
    end
  end

  // One debounce lane per channel
  for (genvar ch = 0; ch < mdr_pkg::CHANNELS; ch++) begin : g_lane
    mdr_pkg::lane_ctrl_t ctrl;
    logic                pin;

    assign enable_vec[ch] = enable_mask[ch / 8][ch % 8];
    assign pullup_vec[ch] = pullup_mask[ch / 8][ch % 8];
    assign ctrl.sample    = sample;
    assign ctrl.clear     = cfg_hit && (int'(cfg_port) == ch / 8);

    if (ch < mdr_pkg::PIN_COUNT) begin : g_pin
      assign pin = pin_levels[ch];
    end else begin : g_nopin
      assign pin = 1'b0;
    end

    mdr_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (ctrl),
      .enable (enable_vec[ch]),
      .pin    (pin),
      .level  (level_vec[ch])
    );
  end

  // Merge the lanes into the report stream
  mdr_report u_report (
    .clk           (clk),
    .rst           (rst),
    .start         (sample),
    .enable_vec    (enable_vec),
    .pullup_vec    (pullup_vec),
    .level_vec     (level_vec),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .report_byte   (report_byte),
    .byte_position (byte_position),
    .last_byte     (last_byte)
  );

endmodule

// ----- tb/sv/multi_input_debounce_reporter_tb.sv -----
`timescale 1ns / 1ps

module multi_input_debounce_reporter_tb;

  localparam int IDLE_PCT        = 15;
  localparam int LATENCY_SLACK   = 16;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int MAX_SHOWN       = 10;
  localparam int RANDOM_PHASES   = 8;
  localparam int PHASE_TICKS     = 55;
  localparam int QUIET_PHASE     = 3;
  localparam int PRESSURE_TICKS  = 40;

  // Register indexes; the two spare codes fall outside the register file
  localparam logic [mdr_pkg::CFG_IDX_W-1:0] REG_PORT0_ENABLE = mdr_pkg::CFG_IDX_W'(0);
  localparam logic [mdr_pkg::CFG_IDX_W-1:0] REG_PORT0_PULLUP = mdr_pkg::CFG_IDX_W'(1);
  localparam logic [mdr_pkg::CFG_IDX_W-1:0] REG_PORT1_ENABLE = mdr_pkg::CFG_IDX_W'(2);
  localparam logic [mdr_pkg::CFG_IDX_W-1:0] REG_PORT1_PULLUP = mdr_pkg::CFG_IDX_W'(3);
  localparam logic [mdr_pkg::CFG_IDX_W-1:0] REG_PORT2_ENABLE = mdr_pkg::CFG_IDX_W'(4);
  localparam logic [mdr_pkg::CFG_IDX_W-1:0] REG_PORT2_PULLUP = mdr_pkg::CFG_IDX_W'(5);
  localparam logic [mdr_pkg::CFG_IDX_W-1:0] REG_SPARE_LO     = mdr_pkg::CFG_IDX_W'(6);
  localparam logic [mdr_pkg::CFG_IDX_W-1:0] REG_SPARE_HI     = mdr_pkg::CFG_IDX_W'(7);

  typedef struct packed {
    logic [7:0] data;
    logic [3:0] pos;
    logic       last;
  } report_entry_t;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  logic [23:0]                   pin_levels;
  logic                          out_valid;
  logic                          out_ready;
  logic [7:0]                    report_byte;
  logic [3:0]                    byte_position;
  logic                          last_byte;
  logic                          cfg_we;
  logic [mdr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [7:0]                    cfg_data;

  // Debouncer image: tick parity, per-channel lanes and the port masks
  bit                         tick_phase;
  bit [mdr_pkg::CHANNELS-1:0] kept_sample;
  bit [mdr_pkg::CHANNELS-1:0] stable_level;
  bit [mdr_pkg::CNT_W-1:0]    agree_run [mdr_pkg::CHANNELS];
  bit [7:0]                   enable_mask [mdr_pkg::NUM_PORTS];
  bit [7:0]                   pullup_mask [mdr_pkg::NUM_PORTS];

  report_entry_t expected_bytes [$];
  int            error_count;
  int            hold_off_left;
  bit            quiet;

  multi_input_debounce_reporter dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .pin_levels    (pin_levels),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .report_byte   (report_byte),
    .byte_position (byte_position),
    .last_byte     (last_byte),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= MAX_SHOWN) begin
      $display("mismatch: %s", msg);
    end
  endtask

  function automatic logic [3:0] channel_nibble(input int ch);
    logic [3:0] nib;
    nib = '0;
    if (enable_mask[ch / 8][ch % 8]) nib |= mdr_pkg::NIB_ENABLE;
    if (pullup_mask[ch / 8][ch % 8]) nib |= mdr_pkg::NIB_PULLUP;
    if (stable_level[ch]) nib |= mdr_pkg::NIB_LEVEL;
    return nib;
  endfunction

  // Store a mask and clear the lanes of its port; ignore unmapped indexes
  function automatic void apply_register(input logic [mdr_pkg::CFG_IDX_W-1:0] idx,
                                         input logic [7:0] value);
    int port;
    port = int'(idx) >> 1;
    if (int'(idx) >= 2 * mdr_pkg::CFG_PORTS || port >= mdr_pkg::NUM_PORTS) return;
    if (idx[0] == mdr_pkg::SEL_ENABLE) enable_mask[port] = value;
    else pullup_mask[port] = value;
    for (int k = 0; k < 8; k++) begin
      kept_sample[port * 8 + k]  = 1'b0;
      stable_level[port * 8 + k] = 1'b0;
      agree_run[port * 8 + k]    = '0;
    end
  endfunction

  // Advance the debouncer by one tick and queue the report it produces
  function automatic void predict_tick(input logic [23:0] pins);
    logic          lvl;
    report_entry_t entry;
    tick_phase = ~tick_phase;
    if (tick_phase) return;
    for (int ch = 0; ch < mdr_pkg::CHANNELS; ch++) begin
      if (!enable_mask[ch / 8][ch % 8]) continue;
      lvl = (ch < mdr_pkg::PIN_COUNT) ? pins[ch] : 1'b0;
      if (lvl == kept_sample[ch]) begin
        if (agree_run[ch] < mdr_pkg::DEBOUNCE_LIMIT) begin
          agree_run[ch]++;
          if (agree_run[ch] == mdr_pkg::DEBOUNCE_LIMIT) stable_level[ch] = lvl;
        end
      end else begin
        agree_run[ch] = '0;
      end
      kept_sample[ch] = lvl;
    end
    for (int pos = 0; pos < mdr_pkg::REPORT_LEN; pos++) begin
      if (pos == 0) entry.data = mdr_pkg::REPORT_HEADER;
      else entry.data = {channel_nibble((pos - 1) * 2), channel_nibble((pos - 1) * 2 + 1)};
      entry.pos  = pos[3:0];
      entry.last = (pos == mdr_pkg::REPORT_LEN - 1);
      expected_bytes.push_back(entry);
    end
  endfunction

  // Offer one tick, with random idle cycles ahead of it, and wait for the transfer
  task automatic send_tick(input logic [23:0] pins);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    pin_levels = pins;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_tick(pins);
  endtask

  // Drop valid and wait until every report byte has arrived and the block settles
  task automatic wait_report_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (LATENCY_SLACK) @(posedge clk);
  endtask

  task automatic write_register(input logic [mdr_pkg::CFG_IDX_W-1:0] idx,
                                input logic [7:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
    apply_register(idx, value);
  endtask

  // Reports straight out of reset: all channels disabled, levels low
  task automatic test_reset_report();
    send_tick(24'hFFFFFF);
    send_tick(24'h000000);
  endtask

  // Settle every channel high, then disable a port and chatter the pins
  task automatic test_debounce_directed();
    wait_report_idle();
    write_register(REG_PORT0_ENABLE, 8'hFF);
    write_register(REG_PORT1_ENABLE, 8'hFF);
    write_register(REG_PORT2_ENABLE, 8'hFF);
    write_register(REG_PORT0_PULLUP, 8'h00);
    write_register(REG_PORT1_PULLUP, 8'hFF);
    write_register(REG_PORT2_PULLUP, 8'hA5);
    repeat (12) send_tick(24'hFFFFFF);
    wait_report_idle();
    write_register(REG_PORT1_ENABLE, 8'h00);
    write_register(REG_SPARE_LO, 8'hFF);
    write_register(REG_SPARE_HI, 8'h3C);
    for (int i = 0; i < 6; i++) begin
      send_tick(i[1] ? 24'hFFFFFF : 24'h000000);
    end
  endtask

  // Hold the output off for a long stretch so the input side backs up
  task automatic test_output_hold_off();
    wait_report_idle();
    write_register(REG_PORT1_ENABLE, 8'h5A);
    hold_off_left = HOLD_OFF_CYCLES;
    repeat (PRESSURE_TICKS) send_tick(24'($urandom_range(24'hFFFFFF)));
  endtask

  // Phases of slowly drifting pin levels under fresh masks, with some noise ticks
  task automatic test_random_ticks();
    logic [23:0] level_now;
    int          flip_odds;
    level_now = '0;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_report_idle();
      for (int r = int'(REG_PORT0_ENABLE); r <= int'(REG_SPARE_HI); r++) begin
        if ($urandom_range(1)) begin
          case ($urandom_range(3))
            0:       write_register(mdr_pkg::CFG_IDX_W'(r), 8'h00);
            1:       write_register(mdr_pkg::CFG_IDX_W'(r), 8'hFF);
            default: write_register(mdr_pkg::CFG_IDX_W'(r), 8'($urandom_range(255)));
          endcase
        end
      end
      quiet = (phase == QUIET_PHASE);
      case ($urandom_range(2))
        0:       flip_odds = 4;
        1:       flip_odds = 16;
        default: flip_odds = 64;
      endcase
      for (int n = 0; n < PHASE_TICKS; n++) begin
        if ($urandom_range(9) == 0) begin
          send_tick(24'($urandom_range(24'hFFFFFF)));
        end else begin
          for (int b = 0; b < mdr_pkg::PIN_COUNT; b++) begin
            if ($urandom_range(flip_odds - 1) == 0) level_now[b] = ~level_now[b];
          end
          send_tick(level_now);
        end
      end
    end
    quiet = 1'b0;
  endtask

  // Receiver: random back-pressure, or a counted hold-off when one is requested
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        out_ready = 1'b0;
        hold_off_left--;
      end else begin
        out_ready = quiet || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Compare each byte transfer with the oldest expected report byte
  initial begin
    report_entry_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && out_ready) begin
        if (expected_bytes.size() == 0) begin
          note_error($sformatf("unexpected byte %02h pos %0d last %0b",
                               report_byte, byte_position, last_byte));
        end else begin
          want = expected_bytes.pop_front();
          if (report_byte !== want.data || byte_position !== want.pos ||
              last_byte !== want.last) begin
            note_error($sformatf("exp %02h pos %0d last %0b, got %02h pos %0d last %0b",
                                 want.data, want.pos, want.last,
                                 report_byte, byte_position, last_byte));
          end
        end
      end
    end
  end

  // End the run when nothing transfers on either side for too long
  initial begin
    int stalled;
    stalled = 0;
    while (stalled < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stalled = 0;
      else stalled++;
    end
    $display("FAIL multi_input_debounce_reporter");
    $finish;
  end

  initial begin
    in_valid      = 1'b0;
    pin_levels    = '0;
    out_ready     = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    hold_off_left = 0;
    quiet         = 1'b0;
    error_count   = 0;
    rst           = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_report();
    test_debounce_directed();
    test_output_hold_off();
    test_random_ticks();

    wait_report_idle();
    if (expected_bytes.size() != 0) note_error("report bytes never arrived");
    if (error_count == 0) begin
      $display("PASS multi_input_debounce_reporter");
    end else begin
      $display("FAIL multi_input_debounce_reporter");
    end
    $finish;
  end

endmodule
